// ===== design/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Poincare ball distance package
// Shared types and constants of the ball distance unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbd_pkg;

  localparam int unsigned MAX_DIM   = 64;
  localparam int unsigned DIM_CNT_W = $clog2(MAX_DIM + 1);
  localparam int unsigned EPS_LSBS  = 1;

  localparam int unsigned ACC_W  = 40;
  localparam int unsigned CURV_W = 16;
  localparam int unsigned DIST_W = 20;

  localparam logic [ACC_W-1:0]  ACC_MAX       = {ACC_W{1'b1}};
  localparam logic [CURV_W-1:0] CURV_RESET    = 16'd4096;
  localparam logic [DIST_W-1:0] DIST_MAX      = {DIST_W{1'b1}};
  localparam logic [31:0]       LN2_Q32       = 32'd2977044472;
  localparam logic [7:0]        EPS_Q30       = 8'(EPS_LSBS);

  typedef struct packed {
    logic signed [15:0] coord_a;
    logic signed [15:0] coord_b;
    logic               last_coord;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              saturated;
    logic              outside_ball;
  } out_t;

  typedef struct packed {
    logic [ACC_W-1:0] diff_sq;
    logic [ACC_W-1:0] norm_a;
    logic [ACC_W-1:0] norm_b;
  } sums_t;

  typedef struct packed {
    logic full;
    logic valid;
  } fifo_stat_t;

endpackage

// ===== design/pbd_front.sv =====
// ----------------------------------------------------------------------------
// Ball distance front end
// Accepts coordinate pairs, accumulates the three saturating sums of
// squares and pushes them into the queue on the last pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pbd_pkg::in_t  in_data_i,
  input  logic          q_full_i,
  output logic          push_o,
  output pbd_pkg::sums_t push_data_o
);
  import pbd_pkg::*;

  sums_t                sums_q, sums_d, upd;
  logic [DIM_CNT_W-1:0] cnt_q, cnt_d;
  logic                 accept;
  logic                 use_it;
  logic signed [16:0]   diff;
  logic [15:0]          ud, ma, mb;

  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] acc, logic [31:0] v);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + (ACC_W+1)'(v);
    return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign use_it     = (DIM_CNT_W'(MAX_DIM) > cnt_q);

  always_comb begin
    diff = 17'(in_data_i.coord_a) - 17'(in_data_i.coord_b);
    ud   = diff[16] ? 16'(-diff) : diff[15:0];
    ma   = in_data_i.coord_a[15] ? 16'(-17'(in_data_i.coord_a)) : 16'(in_data_i.coord_a);
    mb   = in_data_i.coord_b[15] ? 16'(-17'(in_data_i.coord_b)) : 16'(in_data_i.coord_b);
    upd  = sums_q;
    if (use_it) begin
      upd.diff_sq = sat_add(sums_q.diff_sq, 32'(ud) * 32'(ud));
      upd.norm_a  = sat_add(sums_q.norm_a, 32'(ma) * 32'(ma));
      upd.norm_b  = sat_add(sums_q.norm_b, 32'(mb) * 32'(mb));
    end
    sums_d = sums_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (in_data_i.last_coord) begin
        sums_d = '0;
        cnt_d  = '0;
      end else begin
        sums_d = upd;
        if (use_it) cnt_d = cnt_q + 1'b1;
      end
    end
  end

  assign push_o      = accept && in_data_i.last_coord;
  assign push_data_o = upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
      cnt_q  <= '0;
    end else begin
      sums_q <= sums_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== design/pbd_fifo.sv =====
// ----------------------------------------------------------------------------
// Ball distance sum queue
// Two-entry queue of finished sums between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pbd_pkg::sums_t     push_data_i,
  input  logic               pop_i,
  output pbd_pkg::sums_t     pop_data_o,
  output pbd_pkg::fifo_stat_t stat_o
);
  import pbd_pkg::*;

  sums_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.valid = (cnt_q != 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== design/pbd_back.sv =====
// ----------------------------------------------------------------------------
// Ball distance back end
// Sequencer that turns one set of sums into a distance: shared multiplier,
// bit-serial divider, digit-serial square root and squaring log unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pbd_pkg::CURV_W-1:0]  curvature_i,
  input  logic                        q_valid_i,
  input  pbd_pkg::sums_t              q_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pbd_pkg::out_t               out_data_o
);
  import pbd_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MQA   = 5'd1;
  localparam logic [4:0] S_MQB   = 5'd2;
  localparam logic [4:0] S_MND   = 5'd3;
  localparam logic [4:0] S_CHK   = 5'd4;
  localparam logic [4:0] S_WDEN  = 5'd5;
  localparam logic [4:0] S_DEN   = 5'd6;
  localparam logic [4:0] S_QCHK  = 5'd7;
  localparam logic [4:0] S_DIV   = 5'd8;
  localparam logic [4:0] S_SQ1   = 5'd9;
  localparam logic [4:0] S_SQ2   = 5'd10;
  localparam logic [4:0] S_MS    = 5'd11;
  localparam logic [4:0] S_WS    = 5'd12;
  localparam logic [4:0] S_SVAL  = 5'd13;
  localparam logic [4:0] S_NORM  = 5'd14;
  localparam logic [4:0] S_LSQ   = 5'd15;
  localparam logic [4:0] S_LW    = 5'd16;
  localparam logic [4:0] S_LSTEP = 5'd17;
  localparam logic [4:0] S_MLN   = 5'd18;
  localparam logic [4:0] S_WLN   = 5'd19;
  localparam logic [4:0] S_FIN   = 5'd20;
  localparam logic [4:0] S_OUT   = 5'd21;

  logic [4:0]  state_q, state_d;
  sums_t       sums_q, sums_d;
  logic [39:0] mul_a_q, mul_a_d;
  logic [31:0] mul_b_q, mul_b_d;
  logic [71:0] prod_q;
  logic [55:0] qa_q, qa_d, qb_q, qb_d;
  logic [56:0] num_q, num_d;
  logic [31:0] den_q, den_d;
  logic [31:0] rem_q, rem_d;
  logic [53:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] rad_q, rad_d;
  logic [31:0] root_q, root_d, r1_q, r1_d;
  logic [35:0] srem_q, srem_d;
  logic [63:0] n_q, n_d;
  logic [5:0]  p_q, p_d;
  logic [31:0] m_q, m_d;
  logic [23:0] frac_q, frac_d;
  out_t        res_q, res_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  logic [42:0] udiff_a, udiff_b;
  logic [30:0] ua_e, ub;
  logic [32:0] dtrial;
  logic [35:0] st, strial;
  logic [54:0] x_sh;
  logic [32:0] lt;
  logic [71:0] lsum;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    sums_d      = sums_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    qa_d        = qa_q;
    qb_d        = qb_q;
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    rad_d       = rad_q;
    root_d      = root_q;
    r1_d        = r1_q;
    srem_d      = srem_q;
    n_d         = n_q;
    p_d         = p_q;
    m_d         = m_q;
    frac_d      = frac_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;

    udiff_a = {1'b1, 42'd0} - qa_q[42:0];
    udiff_b = {1'b1, 42'd0} - qb_q[42:0];
    ua_e    = udiff_a[42:12] + 31'(EPS_Q30);
    ub      = udiff_b[42:12];
    dtrial  = {rem_q, quo_q[53]};
    st      = {srem_q[33:0], rad_q[63:62]};
    strial  = {2'b00, root_q, 2'b01};
    x_sh    = 55'(quo_q) + 55'(64'd1 << 33);
    lt      = prod_q[63:31];
    lsum    = prod_q + 72'(64'd1 << 39);

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          sums_d  = q_data_i;
          mul_a_d = q_data_i.norm_a;
          mul_b_d = 32'(curvature_i);
          state_d = S_MQA;
        end
      end
      S_MQA: begin
        mul_a_d = sums_q.norm_b;
        state_d = S_MQB;
      end
      S_MQB: begin
        qa_d    = prod_q[55:0];
        mul_a_d = sums_q.diff_sq;
        state_d = S_MND;
      end
      S_MND: begin
        qb_d    = prod_q[55:0];
        state_d = S_CHK;
      end
      S_CHK: begin
        num_d = {prod_q[55:0], 1'b0};
        if (qa_q[55:42] != '0 || qb_q[55:42] != '0) begin
          res_d   = '{distance: '0, saturated: 1'b0, outside_ball: 1'b1};
          state_d = S_OUT;
        end else begin
          mul_a_d = 40'(ua_e);
          mul_b_d = 32'(ub);
          state_d = S_WDEN;
        end
      end
      S_WDEN: state_d = S_DEN;
      S_DEN: begin
        den_d   = prod_q[61:30] + 32'(EPS_Q30);
        state_d = S_QCHK;
      end
      S_QCHK: begin
        // quotient must stay below 2^34, i.e. x below 2^54
        if (den_q == '0 || {9'd0, num_q} >= {den_q, 34'd0}) begin
          res_d   = '{distance: DIST_MAX, saturated: 1'b1, outside_ball: 1'b0};
          state_d = S_OUT;
        end else begin
          rem_d   = 32'(num_q[56:34]);
          quo_d   = {num_q[33:0], 20'd0};
          cnt_d   = 6'd54;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if ({1'b0, den_q} <= dtrial) begin
          rem_d = 32'(dtrial - {1'b0, den_q});
          quo_d = {quo_q[52:0], 1'b1};
        end else begin
          rem_d = dtrial[31:0];
          quo_d = {quo_q[52:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          rad_d   = {2'b00, quo_d, 8'd0};
          root_d  = '0;
          srem_d  = '0;
          cnt_d   = 6'd32;
          state_d = S_SQ1;
        end
      end
      S_SQ1, S_SQ2: begin
        if (strial <= st) begin
          srem_d = st - strial;
          root_d = {root_q[30:0], 1'b1};
        end else begin
          srem_d = st;
          root_d = {root_q[30:0], 1'b0};
        end
        rad_d = {rad_q[61:0], 2'b00};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          if (state_q == S_SQ1) begin
            r1_d    = root_d;
            rad_d   = {1'b0, x_sh, 8'd0};
            root_d  = '0;
            srem_d  = '0;
            cnt_d   = 6'd32;
            state_d = S_SQ2;
          end else begin
            state_d = S_MS;
          end
        end
      end
      S_MS: begin
        mul_a_d = 40'(r1_q);
        mul_b_d = root_q;
        state_d = S_WS;
      end
      S_WS: state_d = S_SVAL;
      S_SVAL: begin
        n_d     = 64'(quo_q) + 64'(prod_q[63:8]) + (64'd1 << 32);
        p_d     = 6'd63;
        state_d = S_NORM;
      end
      S_NORM: begin
        if (n_q[63]) begin
          m_d     = n_q[63:32];
          frac_d  = '0;
          cnt_d   = 6'd24;
          state_d = S_LSQ;
        end else begin
          n_d = {n_q[62:0], 1'b0};
          p_d = p_q - 1'b1;
        end
      end
      S_LSQ: begin
        mul_a_d = 40'(m_q);
        mul_b_d = m_q;
        state_d = S_LW;
      end
      S_LW: state_d = S_LSTEP;
      S_LSTEP: begin
        if (lt[32]) begin
          m_d    = lt[32:1];
          frac_d = {frac_q[22:0], 1'b1};
        end else begin
          m_d    = lt[31:0];
          frac_d = {frac_q[22:0], 1'b0};
        end
        cnt_d   = cnt_q - 1'b1;
        state_d = (cnt_q == 6'd1) ? S_MLN : S_LSQ;
      end
      S_MLN: begin
        mul_a_d = 40'({p_q[4:0], frac_q});
        mul_b_d = LN2_Q32;
        state_d = S_WLN;
      end
      S_WLN: state_d = S_FIN;
      S_FIN: begin
        if (lsum[71:40] > 32'(DIST_MAX)) begin
          res_d = '{distance: DIST_MAX, saturated: 1'b1, outside_ball: 1'b0};
        end else begin
          res_d = '{distance: lsum[59:40], saturated: 1'b0, outside_ball: 1'b0};
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    sums_q  <= sums_d;
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    prod_q  <= 72'(mul_a_q) * 72'(mul_b_q);
    qa_q    <= qa_d;
    qb_q    <= qb_d;
    num_q   <= num_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    rad_q   <= rad_d;
    root_q  <= root_d;
    r1_q    <= r1_d;
    srem_q  <= srem_d;
    n_q     <= n_d;
    p_q     <= p_d;
    m_q     <= m_d;
    frac_q  <= frac_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/poincare_ball_distance_unit.sv =====
// ----------------------------------------------------------------------------
// Poincare ball distance unit
// Streams two points one coordinate pair per transaction and returns their
// hyperbolic distance as unsigned Q4.16 after the pair marked last.
//
// Input channel: in_valid_i / in_stall_o carry coord_a, coord_b (Q1.15) and
// last_coord. Output channel: out_valid_o / out_stall_i carry distance,
// saturated and outside_ball. cfg_we_i writes the curvature (Q4.12).
// A coordinate pair is taken every cycle unless the queue is full; the
// front end adds each pair into its registered sums of squares. The last
// pair hands the sums through a two-entry queue to a sequencer that runs
// per vector 54 divider steps, two 32-step square roots, up to 31 normalize
// shifts and 24 log squarings on one shared multiplier. Vectors whose pairs
// take at least as long as the sequencer run stream with no stall; shorter
// ones stall the input once the queue holds two pending vectors.
// Reset clears the sums, the queue and the sequencer and sets curvature to
// 1.0. A stalled output holds its result while the sequencer finishes the
// next vector and waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module poincare_ball_distance_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pbd_pkg::CURV_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pbd_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pbd_pkg::out_t               out_data_o
);
  import pbd_pkg::*;

  logic [CURV_W-1:0] curv_q;
  logic              push, pop;
  sums_t             push_data, pop_data;
  fifo_stat_t        q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curv_q <= CURV_RESET;
    end else if (cfg_we_i) begin
      curv_q <= cfg_data_i;
    end
  end

  pbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_stat.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pbd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  pbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .curvature_i (curv_q),
    .q_valid_i   (q_stat.valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
